@@ hdl/fifo_extract_all_maximum_defines.svh @@
// Assertion macros used by the queue top level.
`ifndef FIFO_EXTRACT_ALL_MAXIMUM_DEFINES_SVH
`define FIFO_EXTRACT_ALL_MAXIMUM_DEFINES_SVH

// Same-cycle implication, checked while reset is low.
`define FAE_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked while reset is low.
`define FAE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/fae_pkg.sv @@
// Package with the types, constants and codes of the maximum-extract queue.
`timescale 1ns / 1ps
`default_nettype none
package fae_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic REQ_ENQUEUE = 1'b0;
   localparam logic REQ_CALL = 1'b1;

   localparam logic [1:0] STAT_ENQUEUED = 2'd0;
   localparam logic [1:0] STAT_FULL = 2'd1;
   localparam logic [1:0] STAT_CALLED = 2'd2;
   localparam logic [1:0] STAT_EMPTY = 2'd3;

   typedef struct packed {
      logic        req_type;
      logic [15:0] proc_id;
      logic [15:0] wait_hours;
   } req_pkt_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] out_id;
      logic [15:0] out_wait;
      logic        last;
   } rsp_pkt_type;

   typedef struct packed {
      logic [15:0] id;
      logic [15:0] wait_time;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

   typedef struct packed {
      logic             shift_en;
      logic             load_en;
      logic [CNT_W-1:0] pos;
   } chain_cmd_type;

endpackage
`default_nettype wire

@@ hdl/fifo_extract_all_maximum.sv @@
// Top level of the bounded queue that extracts all entries of maximum wait time.
// An enqueue's result is registered for the next cycle.
// A call rotates the whole cell row in the scan state to find the maximum, then once
// more in the emit state to emit matches and recirculate the rest; the next request
// is taken after the return to idle, and a match waiting on the result channel stalls.
// Reset clears the state machine, the entry count and the result valid flag.
`timescale 1ns / 1ps
`default_nettype none
`include "fifo_extract_all_maximum_defines.svh"
module fifo_extract_all_maximum
   import fae_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_valid,
   output logic       req_ready,
   input  req_pkt_type req_data,
   output logic       rsp_valid,
   input  wire logic  rsp_ready,
   output rsp_pkt_type rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } fsm_state_type;

   fsm_state_type    state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] visit_ff, visit_in;
   logic [CNT_W-1:0] match_ff, match_in;
   logic [15:0]      best_ff, best_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_pkt_type      rsp_data_ff, rsp_data_in;

   chain_cmd_type    cmd;
   entry_type        bus_data;
   entry_type        head;
   logic             out_free;
   logic             emit_step;

   fae_chain u_chain (
      .clock    (clock),
      .cmd      (cmd),
      .bus_data (bus_data),
      .head     (head)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      visit_in = visit_ff;
      match_in = match_ff;
      best_in = best_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      cmd = '0;
      bus_data = head;
      emit_step = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = '{status: STAT_ENQUEUED, out_id: '0, out_wait: '0, last: 1'b1};
               if (req_data.req_type == REQ_ENQUEUE) begin
                  if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                     rsp_data_in.status = STAT_FULL;
                  end else begin
                     cmd.load_en = 1'b1;
                     cmd.pos = count_ff;
                     bus_data = '{id: req_data.proc_id, wait_time: req_data.wait_hours};
                     count_in = count_ff + CNT_W'(1);
                  end
               end else if (count_ff == '0) begin
                  rsp_data_in.status = STAT_EMPTY;
               end else begin
                  rsp_valid_in = 1'b0;
                  state_in = ST_SCAN;
                  visit_in = count_ff;
                  best_in = '0;
                  match_in = '0;
               end
            end
         end
         ST_SCAN: begin
            cmd.shift_en = 1'b1;
            cmd.load_en = 1'b1;
            cmd.pos = count_ff - CNT_W'(1);
            if (head.wait_time > best_ff) begin
               best_in = head.wait_time;
               match_in = CNT_W'(1);
            end else if (head.wait_time == best_ff) begin
               match_in = match_ff + CNT_W'(1);
            end
            visit_in = visit_ff - CNT_W'(1);
            if (visit_ff == CNT_W'(1)) begin
               state_in = ST_EMIT;
               visit_in = count_ff;
            end
         end
         ST_EMIT: begin
            cmd.pos = count_ff - CNT_W'(1);
            if (head.wait_time == best_ff) begin
               if (out_free) begin
                  emit_step = 1'b1;
                  cmd.shift_en = 1'b1;
                  count_in = count_ff - CNT_W'(1);
                  match_in = match_ff - CNT_W'(1);
                  rsp_valid_in = 1'b1;
                  rsp_data_in = '{status: STAT_CALLED, out_id: head.id,
                                  out_wait: head.wait_time,
                                  last: (match_ff == CNT_W'(1))};
               end
            end else begin
               emit_step = 1'b1;
               cmd.shift_en = 1'b1;
               cmd.load_en = 1'b1;
            end
            if (emit_step) begin
               visit_in = visit_ff - CNT_W'(1);
               if (visit_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      visit_ff <= visit_in;
      match_ff <= match_in;
      best_ff <= best_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   `FAE_ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH), "entry count overflow")
   `FAE_ASSERT_NEXT(a_scan_finds_match, (state_ff == ST_SCAN) && (visit_ff == CNT_W'(1)), (match_ff != '0) && (state_ff == ST_EMIT), "scan ended without a matching entry")
   `FAE_ASSERT_NEXT(a_emit_drains_matches, (state_ff == ST_EMIT) && emit_step && (visit_ff == CNT_W'(1)), (match_ff == '0) && (state_ff == ST_IDLE), "call ended with matches left")

endmodule
`default_nettype wire

@@ hdl/fae_cell.sv @@
// One queue cell holding an entry, loaded from its neighbor or from the bus.
`timescale 1ns / 1ps
`default_nettype none
module fae_cell
   import fae_pkg::*;
(
   input  wire logic         clock,
   input  cell_ctl_type      ctl,
   input  entry_type         nbr_data,
   input  entry_type         bus_data,
   output entry_type         data
);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      priority if (ctl.load) begin
         entry_in = bus_data;
      end else if (ctl.shift) begin
         entry_in = nbr_data;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign data = entry_ff;

endmodule
`default_nettype wire

@@ hdl/fae_chain.sv @@
// Row of queue cells with the per-cell shift and load decode.
`timescale 1ns / 1ps
`default_nettype none
module fae_chain
   import fae_pkg::*;
(
   input  wire logic    clock,
   input  chain_cmd_type cmd,
   input  entry_type    bus_data,
   output entry_type    head
);

   entry_type cell_data [QUEUE_DEPTH];

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      cell_ctl_type ctl;
      entry_type    nbr;

      assign ctl.shift = cmd.shift_en && (CNT_W'(i) < cmd.pos);
      assign ctl.load = cmd.load_en && (CNT_W'(i) == cmd.pos);

      if (i < QUEUE_DEPTH - 1) begin : g_mid
         assign nbr = cell_data[i + 1];
      end else begin : g_end
         assign nbr = bus_data;
      end

      fae_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .nbr_data (nbr),
         .bus_data (bus_data),
         .data     (cell_data[i])
      );
   end

   assign head = cell_data[0];

endmodule
`default_nettype wire

@@ bench/fifo_extract_all_maximum_test.sv @@
// Self-checking testbench for the queue that extracts all entries of maximum wait time.
`timescale 1ns / 1ps
module fifo_extract_all_maximum_test;
   import fae_pkg::*;

   typedef struct {
      req_pkt_type pkt;
      bit          hold_for_drain;
   } queued_request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_pkt_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_pkt_type rsp_data;

   queued_request_type pending_requests[$];
   rsp_pkt_type     rsp_due[$];
   entry_type       held_entries[$];

   int mismatch_count = 0;
   int sent_count = 0;
   int call_count = 0;
   int full_count = 0;
   int empty_count = 0;
   int checked_count = 0;

   int          send_gap = 0;
   bit          send_quiet = 1'b0;
   logic        valid_next;
   req_pkt_type data_next;
   queued_request_type head_request;

   int          recv_stall = 0;
   bit          recv_quiet = 1'b0;
   logic        ready_next;
   rsp_pkt_type want;

   fifo_extract_all_maximum uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Applies one accepted request to the queue model and records the results it must give.
   function automatic void predict_queue_rsp(input req_pkt_type r);
      rsp_pkt_type res;
      entry_type   kept[$];
      entry_type   e;
      logic [15:0] top_wait;
      int          first_hit;
      res = '0;
      res.last = 1'b1;
      sent_count++;
      if (r.req_type == REQ_ENQUEUE) begin
         if (held_entries.size() >= QUEUE_DEPTH) begin
            res.status = STAT_FULL;
            full_count++;
         end else begin
            e.id = r.proc_id;
            e.wait_time = r.wait_hours;
            held_entries.push_back(e);
            res.status = STAT_ENQUEUED;
         end
         rsp_due.push_back(res);
         return;
      end
      call_count++;
      if (held_entries.size() == 0) begin
         res.status = STAT_EMPTY;
         empty_count++;
         rsp_due.push_back(res);
         return;
      end
      top_wait = '0;
      foreach (held_entries[i])
         if (held_entries[i].wait_time > top_wait) top_wait = held_entries[i].wait_time;
      first_hit = rsp_due.size();
      foreach (held_entries[i]) begin
         if (held_entries[i].wait_time == top_wait) begin
            res.status = STAT_CALLED;
            res.out_id = held_entries[i].id;
            res.out_wait = held_entries[i].wait_time;
            res.last = 1'b0;
            rsp_due.push_back(res);
         end else begin
            kept.push_back(held_entries[i]);
         end
      end
      rsp_due[rsp_due.size() - 1].last = 1'b1;
      held_entries = kept;
   endfunction

   function automatic void add_request(input logic kind, input logic [15:0] id,
                                       input logic [15:0] hours, input bit drain);
      queued_request_type q;
      q.pkt.req_type = kind;
      q.pkt.proc_id = id;
      q.pkt.wait_hours = hours;
      q.hold_for_drain = drain;
      pending_requests.push_back(q);
   endfunction

   // Mostly a few small values so that ties are common, sometimes the extremes.
   function automatic logic [15:0] pick_wait();
      case ($urandom_range(0, 3))
         0, 1: begin
            return 16'($urandom_range(0, 3));
         end
         2: begin
            return 16'($urandom);
         end
         default: begin
            return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         end
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = $urandom_range(0, 9);
      end else begin
         valid_next = req_valid;
         data_next = req_data;
         if (req_valid && req_ready) begin
            predict_queue_rsp(req_data);
            valid_next = 1'b0;
            if ($urandom_range(0, 24) == 0) send_quiet = !send_quiet;
            send_gap = send_quiet ? 0 : $urandom_range(0, 9);
         end
         if (!valid_next && pending_requests.size() > 0) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (!(pending_requests[0].hold_for_drain && rsp_due.size() > 0)) begin
               head_request = pending_requests.pop_front();
               data_next = head_request.pkt;
               valid_next = 1'b1;
            end
         end
         req_valid <= valid_next;
         req_data <= data_next;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_stall = $urandom_range(0, 9);
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_due.size() == 0) begin
               report_mismatch($sformatf("result with none pending: %p", rsp_data));
            end else begin
               want = rsp_due.pop_front();
               checked_count++;
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status %0d, wanted %0d",
                                            rsp_data.status, want.status));
               if (rsp_data.out_id !== want.out_id)
                  report_mismatch($sformatf("out_id %h, wanted %h",
                                            rsp_data.out_id, want.out_id));
               if (rsp_data.out_wait !== want.out_wait)
                  report_mismatch($sformatf("out_wait %h, wanted %h",
                                            rsp_data.out_wait, want.out_wait));
               if (rsp_data.last !== want.last)
                  report_mismatch($sformatf("last %b, wanted %b",
                                            rsp_data.last, want.last));
            end
            if ($urandom_range(0, 29) == 0) recv_quiet = !recv_quiet;
            recv_stall = recv_quiet ? 0 : $urandom_range(0, 9);
         end
         ready_next = 1'b1;
         if (recv_stall > 0) begin
            recv_stall--;
            ready_next = 1'b0;
         end
         rsp_ready <= ready_next;
      end
   end

   initial begin
      int random_count;
      int burst;
      int calls;
      add_request(REQ_CALL, 16'hFFFF, 16'hFFFF, 1'b0);
      add_request(REQ_ENQUEUE, 16'h0000, 16'h0000, 1'b0);
      add_request(REQ_ENQUEUE, 16'hFFFF, 16'h0000, 1'b0);
      add_request(REQ_ENQUEUE, 16'h1234, 16'h0000, 1'b0);
      add_request(REQ_CALL, 16'h0000, 16'h0000, 1'b0);
      add_request(REQ_CALL, 16'hA5A5, 16'h5A5A, 1'b0);
      for (int i = 0; i < QUEUE_DEPTH; i++)
         add_request(REQ_ENQUEUE, 16'(i * 4099),
                     (i == 3 || i == 12) ? 16'hFFFF : 16'($urandom_range(0, 16'hFFFE)),
                     i == 0);
      add_request(REQ_ENQUEUE, 16'hBEEF, 16'hFFFF, 1'b0);
      add_request(REQ_CALL, 16'h0000, 16'h0000, 1'b0);
      add_request(REQ_CALL, 16'h0000, 16'h0000, 1'b0);
      random_count = 0;
      while (random_count < 190) begin
         burst = $urandom_range(1, 18);
         for (int k = 0; k < burst; k++)
            add_request(REQ_ENQUEUE, 16'($urandom), pick_wait(), $urandom_range(0, 29) == 0);
         calls = $urandom_range(1, 3);
         for (int k = 0; k < calls; k++)
            add_request(REQ_CALL, 16'($urandom), 16'($urandom), $urandom_range(0, 29) == 0);
         random_count += burst + calls;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || rsp_due.size() != 0);
      repeat (60) @(posedge clock);
      $display("Sent %0d requests: %0d calls, %0d on an empty queue, %0d refused as full.",
               sent_count, call_count, empty_count, full_count);
      $display("Checked %0d results against the queue model.", checked_count);
      if (mismatch_count == 0)
         $display("fifo_extract_all_maximum_test OK");
      else
         $display("fifo_extract_all_maximum_test NOT OK");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Run timed out with %0d requests and %0d results outstanding.",
               pending_requests.size(), rsp_due.size());
      $display("fifo_extract_all_maximum_test NOT OK");
      $finish;
   end

endmodule

@@ fifo_extract_all_maximum.f @@
+incdir+hdl
hdl/fae_pkg.sv
hdl/fae_cell.sv
hdl/fae_chain.sv
hdl/fifo_extract_all_maximum.sv
bench/fifo_extract_all_maximum_test.sv
